[hdl/kmcb_pkg.sv]
// Shared types, constants and the keymap for the key matrix character buffer.
// Depends on nothing; every other file of the block uses it by scoped names.

package kmcb_pkg;

   // Field widths of the channel words
   localparam int KEY_W   = 64;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 2;

   // Key walk
   localparam int KEY_COUNT = 64;
   localparam int IDX_W     = 6;
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(KEY_COUNT - 1);

   // Modifier nibble inside the snapshot
   localparam int MOD_LSB   = 36;
   localparam int MOD_W     = 4;
   localparam int FN_BIT    = 1;
   localparam int SHIFT_BIT = 2;
   localparam logic [KEY_W-1:0] MOD_CLEAR_MASK = ~(KEY_W'(8'h0f) << MOD_LSB);

   // Request function codes
   localparam logic FUNC_SNAPSHOT = 1'b0;
   localparam logic FUNC_TAKE     = 1'b1;

   // Characters touched by the shift rules
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_CASE_OFS = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2e;
   localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3a;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2c;
   localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3b;

   // Keymap: plain half first, fn half second
   localparam logic [CHAR_W-1:0] KEY_TABLE [0:127] = '{
      8'h71, 8'h6f, 8'h70, 8'h2c, 8'h08, 8'h00, 8'h61, 8'h73,
      8'h77, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c,
      8'h65, 8'h2e, 8'h00, 8'h0d, 8'h00, 8'h7a, 8'h78, 8'h63,
      8'h72, 8'h76, 8'h62, 8'h6e, 8'h6d, 8'h20, 8'h00, 8'h00,
      8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h31, 8'h39, 8'h30, 8'h3d, 8'h08, 8'h00, 8'h2a, 8'h2b,
      8'h32, 8'h23, 8'h2d, 8'h5f, 8'h28, 8'h29, 8'h26, 8'h21,
      8'h33, 8'h3f, 8'h00, 8'h0d, 8'h00, 8'h00, 8'h24, 8'h00,
      8'h34, 8'h2f, 8'h5c, 8'h22, 8'h27, 8'h40, 8'h00, 8'h00,
      8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h37, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h38, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // take the request word
      logic scan_step;  // examine one key bit
      logic pop;        // pop one character if any
      logic emit;       // move the result into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic take;       // registered request is a take
      logic scan_last;  // current key bit is the last one
      logic out_free;   // output register can take a word this cycle
   } status_type;

   // Map one key index through the keymap and apply the modifiers
   function automatic logic [CHAR_W-1:0] map_key(input logic [IDX_W-1:0] idx,
                                                 input logic [MOD_W-1:0] mods);
      logic [CHAR_W-1:0] code;
      code = KEY_TABLE[{1'b0, idx}];
      if (mods[FN_BIT]) begin
         code = KEY_TABLE[{1'b1, idx}];
      end else if (mods[SHIFT_BIT]) begin
         if (code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            code = code - CHAR_CASE_OFS;
         end else if (code == CHAR_PERIOD) begin
            code = CHAR_COLON;
         end else if (code == CHAR_COMMA) begin
            code = CHAR_SEMI;
         end
      end
      return code;
   endfunction

endpackage

[hdl/kmcb_req_if.sv]
// Request channel: valid/ready handshake carrying func and key_state.
// Depends on kmcb_pkg for the field widths.

interface kmcb_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [kmcb_pkg::KEY_W-1:0] key_state;

   modport source (output valid, func, key_state, input ready);
   modport sink   (input valid, func, key_state, output ready);
endinterface

[hdl/kmcb_rsp_if.sv]
// Response channel: valid/ready handshake carrying one popped character and count.
// Depends on kmcb_pkg for the field widths.

interface kmcb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kmcb_pkg::CHAR_W-1:0]  char_out;
   logic                         char_valid;
   logic [kmcb_pkg::COUNT_W-1:0] buffered_count;

   modport source (output valid, char_out, char_valid, buffered_count, input ready);
   modport sink   (input valid, char_out, char_valid, buffered_count, output ready);
endinterface

[hdl/key_matrix_press_to_char_buffer.sv]
// Top level of the key matrix character buffer: controller and datapath.
// Depends on kmcb_pkg, kmcb_req_if, kmcb_rsp_if, kmcb_ctrl and kmcb_datapath.
//
//   channel   dir  fields                                  handshake
//   req_chan  in   func, key_state[63:0]                   valid / ready
//   rsp_chan  out  char_out[7:0], char_valid, buffered_count[1:0]  valid / ready
//
// A snapshot word is captured, then its key bits are walked one per cycle (the
// scan shifter), then the result is emitted.
// A take word is captured, dispatched past the key walk, popped from the
// registered ring read and emitted.
// The next word is accepted once the result sits in the output register,
// even while that word still waits; a stalled output holds the emit step.
// Synchronous active-high reset clears the pointers, previous snapshot and
// output valid; the ring contents are not cleared.

module key_matrix_press_to_char_buffer #(
   parameter int RING_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   kmcb_req_if.sink    req_chan,
   kmcb_rsp_if.source  rsp_chan
);

   kmcb_pkg::cmd_type    cmd;
   kmcb_pkg::status_type status;
   logic                 ctl_ready;

   // Sequencer
   kmcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = ctl_ready;

   // Datapath
   kmcb_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_chan.func),
      .req_key_state      (req_chan.key_state),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_char_out       (rsp_chan.char_out),
      .rsp_char_valid     (rsp_chan.char_valid),
      .rsp_buffered_count (rsp_chan.buffered_count)
   );

endmodule

[hdl/kmcb_ctrl.sv]
// Sequencer of the key matrix character buffer: accept, walk keys or pop, emit.
// Depends on kmcb_pkg for the command and status structs.

module kmcb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kmcb_pkg::status_type status,
   output kmcb_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_POP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode commands and next state
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // a take word skips the key walk
            if (status.take) begin
               state_in = S_POP;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/kmcb_datapath.sv]
// Datapath: previous snapshot, key walk shifter, character ring and output register.
// Depends on kmcb_pkg for widths, keymap and the command and status structs.

module kmcb_datapath #(
   parameter int RING_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kmcb_pkg::cmd_type                  cmd,
   output kmcb_pkg::status_type               status,
   input  logic                               req_func,
   input  logic [kmcb_pkg::KEY_W-1:0]         req_key_state,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [kmcb_pkg::CHAR_W-1:0]        rsp_char_out,
   output logic                               rsp_char_valid,
   output logic [kmcb_pkg::COUNT_W-1:0]       rsp_buffered_count
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = PTR_W + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   logic [kmcb_pkg::KEY_W-1:0]  prev_keys_ff;
   logic [kmcb_pkg::KEY_W-1:0]  fresh_ff;
   logic [kmcb_pkg::MOD_W-1:0]  mods_ff;
   logic [kmcb_pkg::IDX_W-1:0]  idx_ff;
   logic                        take_ff;
   logic [PTR_W-1:0]            wp_ff;
   logic [PTR_W-1:0]            rp_ff;
   logic [kmcb_pkg::CHAR_W-1:0] ring_ff [RING_DEPTH];
   logic [kmcb_pkg::CHAR_W-1:0] ring_rd_ff;
   logic [kmcb_pkg::CHAR_W-1:0] char_ff;
   logic                        char_valid_ff;
   logic                        out_valid_ff;
   logic [kmcb_pkg::CHAR_W-1:0] out_char_ff;
   logic                        out_char_valid_ff;
   logic [kmcb_pkg::COUNT_W-1:0] out_count_ff;

   logic [kmcb_pkg::KEY_W-1:0]  masked_keys;
   logic [kmcb_pkg::CHAR_W-1:0] mapped_code;
   logic                        push;
   logic [PTR_W-1:0]            wp_next;
   logic [PTR_W-1:0]            rp_next;
   logic [CNT_W-1:0]            count;
   logic                        nonempty;

   assign masked_keys = req_key_state & kmcb_pkg::MOD_CLEAR_MASK;
   assign mapped_code = kmcb_pkg::map_key(idx_ff, mods_ff);
   assign push        = cmd.scan_step & fresh_ff[0];
   assign wp_next     = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
   assign rp_next     = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);

   // Count modulo the ring depth
   always_comb begin
      count = {1'b0, wp_ff} - {1'b0, rp_ff};
      if (wp_ff < rp_ff) begin
         count = count + CNT_W'(RING_DEPTH);
      end
   end
   assign nonempty = (count != '0);

   assign status.take      = take_ff;
   assign status.scan_last = (idx_ff == kmcb_pkg::SCAN_LAST);
   assign status.out_free  = ~out_valid_ff | rsp_ready;

   // Capture the request word, advance the key walk and latch a popped character
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         take_ff       <= (req_func == kmcb_pkg::FUNC_TAKE);
         idx_ff        <= '0;
         mods_ff       <= req_key_state[kmcb_pkg::MOD_LSB +: kmcb_pkg::MOD_W];
         char_ff       <= '0;
         char_valid_ff <= 1'b0;
         fresh_ff      <= masked_keys & ~prev_keys_ff;
      end else if (cmd.scan_step) begin
         idx_ff   <= idx_ff + kmcb_pkg::IDX_W'(1);
         fresh_ff <= fresh_ff >> 1;
      end else if (cmd.pop && nonempty) begin
         char_ff       <= ring_rd_ff;
         char_valid_ff <= 1'b1;
      end
   end

   // Hold the previous snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
      end else if (cmd.load && req_func == kmcb_pkg::FUNC_SNAPSHOT) begin
         prev_keys_ff <= masked_keys;
      end
   end

   // Ring pointers, no overflow guard
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_next;
         end
         if (cmd.pop && nonempty) begin
            rp_ff <= rp_next;
         end
      end
   end

   // Ring storage with registered read at the read pointer
   always_ff @(posedge clock) begin
      if (push) begin
         ring_ff[wp_ff] <= mapped_code;
      end
      ring_rd_ff <= ring_ff[rp_ff];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_char_ff       <= char_ff;
         out_char_valid_ff <= char_valid_ff;
         out_count_ff      <= count[kmcb_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_char_out       = out_char_ff;
   assign rsp_char_valid     = out_char_valid_ff;
   assign rsp_buffered_count = out_count_ff;

`ifndef ASSERT_OFF
   a_wp_only_on_push: assert property (@(posedge clock) disable iff (reset)
      !push |=> $stable(wp_ff))
      else $error("write pointer moved without a push");

   a_rp_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      !cmd.pop |=> $stable(rp_ff))
      else $error("read pointer moved without a pop");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result emitted over a word still waiting");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> out_valid_ff)
      else $error("output register not valid after emit");

   a_walk_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (idx_ff == '0))
      else $error("key walk did not restart at index zero");
`endif

endmodule
